FILE: src/source_tokenizer_defines.svh
// assertion macros shared by the tokenizer rtl
// expects clk and arst_n in the scope of each use
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRCTOK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SRCTOK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRCTOK_ASSERT(lbl, prop, msg)
`define SRCTOK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/srctok_pkg.sv
// types, token codes and character tables of the source tokenizer
// no dependencies
`timescale 1ns / 1ps

package srctok_pkg;

	localparam logic [5:0] K_EOF    = 6'd0;
	localparam logic [5:0] K_LPAREN = 6'd1;
	localparam logic [5:0] K_RPAREN = 6'd2;
	localparam logic [5:0] K_LBRACE = 6'd3;
	localparam logic [5:0] K_RBRACE = 6'd4;
	localparam logic [5:0] K_COLON  = 6'd5;
	localparam logic [5:0] K_SEMI   = 6'd6;
	localparam logic [5:0] K_COMMA  = 6'd7;
	localparam logic [5:0] K_ASSIGN = 6'd8;
	localparam logic [5:0] K_NOT    = 6'd10;
	localparam logic [5:0] K_PLUS   = 6'd12;
	localparam logic [5:0] K_MINUS  = 6'd14;
	localparam logic [5:0] K_STAR   = 6'd16;
	localparam logic [5:0] K_SLASH  = 6'd18;
	localparam logic [5:0] K_PCT    = 6'd20;
	localparam logic [5:0] K_LT     = 6'd22;
	localparam logic [5:0] K_GT     = 6'd24;
	localparam logic [5:0] K_AND    = 6'd26;
	localparam logic [5:0] K_OR     = 6'd27;
	localparam logic [5:0] K_STRING = 6'd28;
	localparam logic [5:0] K_NUMBER = 6'd29;
	localparam logic [5:0] K_IDENT  = 6'd30;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_CHAR   = 2'd1;
	localparam logic [1:0] ERR_STRING = 2'd2;

	localparam int KW_COUNT = 8;
	localparam int KW_TEXT_BITS = 48;

	// keyword text, last character in the lowest byte
	localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		48'h0000_656C_7365, 48'h0000_0000_666E, 48'h0000_0000_6966,
		48'h0000_006C_6574, 48'h0000_006D_7574, 48'h7265_7475_726E,
		48'h0000_7472_7565, 48'h0066_616C_7365
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd4, 3'd2, 3'd2, 3'd3, 3'd3, 3'd6, 3'd4, 3'd5
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd37
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [1:0]  err;
		logic        fin;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	// operators that may take a trailing '='
	function automatic logic [5:0] op_base(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"=": k = K_ASSIGN;
			"!": k = K_NOT;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"%": k = K_PCT;
			"<": k = K_LT;
			">": k = K_GT;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			":": k = K_COLON;
			";": k = K_SEMI;
			",": k = K_COMMA;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

endpackage

FILE: src/source_tokenizer.sv
// source tokenizer top level: scanner state, token build and result queue
// depends on srctok_pkg and source_tokenizer_defines.svh
`timescale 1ns / 1ps
//
// Input stream: one source byte per beat in s_tdata[7:0]; a beat with s_tlast
// high is the end of source and its byte is ignored. Output stream: one token
// per beat, kind and error code in m_tuser, offset, length and line in
// m_tdata, m_tlast high on the eof token or on an error token.
// Each accepted byte is decoded in the cycle it is taken; the tokens it
// completes (zero, one or two) are registered into a four-entry result queue
// that feeds the master side. A token that needs a byte of lookahead
// completes on the beat after its last byte. Throughput is one byte per
// cycle while s_tready is high, i.e. while the queue has at least two free
// entries, so a receiver that stalls holds the input back after at most four
// results are buffered; the queue drains one token per cycle while m_tready
// is high. After an error token, bytes are swallowed with no output until the
// end of source, which then produces nothing. After every end of source the
// scanner returns to its reset state, ready for the next source.
// Reset (arst_n low) empties the queue and restarts at offset 0, line 1.
//
module source_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // character
	input  logic        s_tlast,   // end_marker
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // start_offset, lexeme_length, line_number
	output logic [7:0]  m_tuser,   // token_kind, error_code
	output logic        m_tlast    // final_token
);
	import srctok_pkg::*;

	`include "source_tokenizer_defines.svh"

	localparam int KWB = 8 * KEYWORD_CHARS;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [POSITION_BITS-1:0] ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] TWO = POSITION_BITS'(2);

	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_IDENT    = 3'd1;
	localparam logic [2:0] MODE_NUMBER   = 3'd2;
	localparam logic [2:0] MODE_STRING   = 3'd3;
	localparam logic [2:0] MODE_COMMENT  = 3'd4;
	localparam logic [2:0] MODE_OPERATOR = 3'd5;

	logic [2:0]               mode_q, mode_n;
	logic [7:0]               pend_q, pend_n;
	logic [POSITION_BITS-1:0] tok_q, tok_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [POSITION_BITS-1:0] line_q, line_n;
	logic [KWB-1:0]           kw_q, kw_n;
	logic                     disc_q, disc_n;

	token_t     fifo_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	logic                     acc, pop;
	logic [7:0]               c;
	logic [POSITION_BITS-1:0] span;
	logic [5:0]               ident_kind;
	logic                     ident_ch, amp_or, idle_go;
	token_t                   ra, rb;
	logic                     ra_v, rb_v;

	function automatic logic [15:0] fit16(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + ONE;
	endfunction

	function automatic token_t mk(input logic [5:0] kind, input logic [POSITION_BITS-1:0] st,
			input logic [POSITION_BITS-1:0] ln, input logic [POSITION_BITS-1:0] line,
			input logic [1:0] err, input logic fin);
		token_t t;
		t.kind  = kind;
		t.start = fit16(st);
		t.len   = fit16(ln);
		t.line  = fit16(line);
		t.err   = err;
		t.fin   = fin;
		return t;
	endfunction

	assign acc = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;
	assign c = s_tdata;
	assign span = (pos_q >= tok_q) ? pos_q - tok_q : '0;
	assign ident_ch = is_alpha(c) || is_digit(c) || (c == "_");
	assign amp_or = (pend_q == "&") || (pend_q == "|");

	always_comb begin
		ident_kind = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if ((span == POSITION_BITS'(KW_LEN[i])) && (kw_q == KWB'(KW_TEXT[i])))
				ident_kind = KW_KIND[i];
		end
	end

	always_comb begin
		mode_n = mode_q;
		pend_n = pend_q;
		tok_n = tok_q;
		pos_n = pos_q;
		line_n = line_q;
		kw_n = kw_q;
		disc_n = disc_q;
		ra = '0;
		rb = '0;
		ra_v = 1'b0;
		rb_v = 1'b0;
		idle_go = 1'b0;
		if (acc) begin
			if (s_tlast) begin
				if (!disc_q) begin
					rb = mk(K_EOF, pos_q, '0, line_q, ERR_NONE, 1'b1);
					rb_v = 1'b1;
					case (mode_q)
						MODE_IDENT: begin
							ra = mk(ident_kind, tok_q, span, line_q, ERR_NONE, 1'b0);
							ra_v = 1'b1;
						end
						MODE_NUMBER: begin
							ra = mk(K_NUMBER, tok_q, span, line_q, ERR_NONE, 1'b0);
							ra_v = 1'b1;
						end
						MODE_STRING: begin
							ra = mk(K_EOF, tok_q, span, line_q, ERR_STRING, 1'b1);
							ra_v = 1'b1;
							rb_v = 1'b0;
						end
						MODE_OPERATOR: begin
							ra_v = 1'b1;
							if (amp_or) begin
								ra = mk(K_EOF, tok_q, ONE, line_q, ERR_CHAR, 1'b1);
								rb_v = 1'b0;
							end else begin
								ra = mk(op_base(pend_q), tok_q, ONE, line_q, ERR_NONE, 1'b0);
							end
						end
						default: ;
					endcase
				end
				mode_n = MODE_IDLE;
				pend_n = '0;
				tok_n = '0;
				pos_n = '0;
				line_n = ONE;
				kw_n = '0;
				disc_n = 1'b0;
			end else begin
				pos_n = sat_inc(pos_q);
				if (!disc_q) begin
					case (mode_q)
						MODE_IDENT: begin
							if (ident_ch) begin
								kw_n = {kw_q[KWB-9:0], c};
							end else begin
								ra = mk(ident_kind, tok_q, span, line_q, ERR_NONE, 1'b0);
								ra_v = 1'b1;
								idle_go = 1'b1;
							end
						end
						MODE_NUMBER: begin
							if (!is_digit(c)) begin
								ra = mk(K_NUMBER, tok_q, span, line_q, ERR_NONE, 1'b0);
								ra_v = 1'b1;
								idle_go = 1'b1;
							end
						end
						MODE_STRING: begin
							if (c == "\"") begin
								ra = mk(K_STRING, tok_q, span, line_q, ERR_NONE, 1'b0);
								ra_v = 1'b1;
								mode_n = MODE_IDLE;
							end else if (c == "\n") begin
								line_n = sat_inc(line_q);
							end
						end
						MODE_COMMENT: begin
							if (c == "\n")
								idle_go = 1'b1;
						end
						MODE_OPERATOR: begin
							if (amp_or) begin
								ra_v = 1'b1;
								if (c == pend_q) begin
									ra = mk((pend_q == "&") ? K_AND : K_OR, tok_q, TWO, line_q,
										ERR_NONE, 1'b0);
									mode_n = MODE_IDLE;
								end else begin
									ra = mk(K_EOF, tok_q, ONE, line_q, ERR_CHAR, 1'b1);
									disc_n = 1'b1;
								end
							end else if ((pend_q == "/") && (c == "/")) begin
								mode_n = MODE_COMMENT;
							end else begin
								ra_v = 1'b1;
								mode_n = MODE_IDLE;
								if (c == "=") begin
									ra = mk(op_base(pend_q) + 6'd1, tok_q, TWO, line_q,
										ERR_NONE, 1'b0);
								end else begin
									ra = mk(op_base(pend_q), tok_q, ONE, line_q, ERR_NONE, 1'b0);
									idle_go = 1'b1;
								end
							end
						end
						default: idle_go = 1'b1;
					endcase
					// byte that may open a new token
					if (idle_go) begin
						mode_n = MODE_IDLE;
						if ((c == " ") || (c == "\r")) begin
							mode_n = MODE_IDLE;
						end else if (c == "\n") begin
							line_n = sat_inc(line_q);
						end else if (single_kind(c) != K_EOF) begin
							rb = mk(single_kind(c), pos_q, ONE, line_q, ERR_NONE, 1'b0);
							rb_v = 1'b1;
						end else if ((op_base(c) != K_EOF) || (c == "&") || (c == "|")) begin
							mode_n = MODE_OPERATOR;
							pend_n = c;
							tok_n = pos_q;
						end else if (c == "\"") begin
							mode_n = MODE_STRING;
							tok_n = sat_inc(pos_q);
						end else if (is_digit(c)) begin
							mode_n = MODE_NUMBER;
							tok_n = pos_q;
						end else if (ident_ch) begin
							mode_n = MODE_IDENT;
							tok_n = pos_q;
							kw_n = {{(KWB-8){1'b0}}, c};
						end else begin
							rb = mk(K_EOF, pos_q, ONE, line_q, ERR_CHAR, 1'b1);
							rb_v = 1'b1;
							disc_n = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= '0;
			tok_q <= '0;
			pos_q <= '0;
			line_q <= ONE;
			kw_q <= '0;
			disc_q <= 1'b0;
		end else begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			tok_q <= tok_n;
			pos_q <= pos_n;
			line_q <= line_n;
			kw_q <= kw_n;
			disc_q <= disc_n;
		end
	end

	// result queue, earlier token first
	always_ff @(posedge clk) begin
		if (ra_v) begin
			fifo_q[wp_q] <= ra;
			if (rb_v)
				fifo_q[wp_q + 2'd1] <= rb;
		end else if (rb_v) begin
			fifo_q[wp_q] <= rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + {1'b0, ra_v} + {1'b0, rb_v};
			if (pop)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, ra_v} + {2'b0, rb_v} - {2'b0, pop};
		end
	end

	assign s_tready = (cnt_q <= 3'd2);
	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata = {fifo_q[rp_q].line, fifo_q[rp_q].len, fifo_q[rp_q].start};
	assign m_tuser = {fifo_q[rp_q].err, fifo_q[rp_q].kind};
	assign m_tlast = fifo_q[rp_q].fin;

	`SRCTOK_ASSERT(a_queue_bound, cnt_q <= 3'd4, "result queue overflow")
	`SRCTOK_ASSERT(a_discard_silent, (acc && disc_q) |-> (!ra_v && !rb_v), "token while discarding")
	`SRCTOK_ASSERT(a_end_restart, (acc && s_tlast) |=> (mode_q == MODE_IDLE && pos_q == '0),
		"scanner not restarted after end of source")
	`SRCTOK_ASSERT_ALWAYS(a_line_nonzero, (!arst_n) || (line_q != '0), "line count is zero")

endmodule

FILE: tb/tb_source_tokenizer.sv
// testbench for source_tokenizer: random and directed sources checked beat by beat
// against a scanner model kept inside this file; depends on srctok_pkg and the rtl
`timescale 1ns / 1ps

module tb_source_tokenizer;
	import srctok_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_PRINTS = 40;
	localparam logic [15:0] POS_TOP = 16'hFFFF;

	localparam logic [5:0] KIND_ELSE   = 6'd31;
	localparam logic [5:0] KIND_FN     = 6'd32;
	localparam logic [5:0] KIND_IF     = 6'd33;
	localparam logic [5:0] KIND_LET    = 6'd34;
	localparam logic [5:0] KIND_MUT    = 6'd35;
	localparam logic [5:0] KIND_RETURN = 6'd36;
	localparam logic [5:0] KIND_BOOL   = 6'd37;

	localparam logic [47:0] TXT_ELSE   = "else";
	localparam logic [47:0] TXT_FN     = "fn";
	localparam logic [47:0] TXT_IF     = "if";
	localparam logic [47:0] TXT_LET    = "let";
	localparam logic [47:0] TXT_MUT    = "mut";
	localparam logic [47:0] TXT_RETURN = "return";
	localparam logic [47:0] TXT_TRUE   = "true";
	localparam logic [47:0] TXT_FALSE  = "false";

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [2:0] {
		LEX_IDLE, LEX_WORD, LEX_NUMBER, LEX_STRING, LEX_COMMENT, LEX_OPERATOR
	} lex_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	// scanner model state
	lex_mode_e   lex_mode;
	logic [7:0]  held_op;
	logic [15:0] tok_start;
	logic [15:0] byte_pos;
	logic [15:0] line_cnt;
	logic [47:0] word_tail;
	logic        discarding;
	token_t      tokens_due[$];

	logic [7:0]  src_q[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;

	source_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sat_bump(input logic [15:0] v);
		return (v == POS_TOP) ? v : v + 16'd1;
	endfunction

	function automatic logic [15:0] run_length(input logic [15:0] from);
		return (byte_pos >= from) ? byte_pos - from : 16'd0;
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic [5:0] assign_op_kind(input logic [7:0] c);
		case (c)
			"=": return K_ASSIGN;
			"!": return K_NOT;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"%": return K_PCT;
			"<": return K_LT;
			">": return K_GT;
			default: return K_EOF;
		endcase
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		case (c)
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			":": return K_COLON;
			";": return K_SEMI;
			",": return K_COMMA;
			default: return K_EOF;
		endcase
	endfunction

	function automatic logic [5:0] word_kind(input logic [47:0] tail, input logic [15:0] len);
		if (len == 16'd4 && tail == TXT_ELSE) return KIND_ELSE;
		if (len == 16'd2 && tail == TXT_FN) return KIND_FN;
		if (len == 16'd2 && tail == TXT_IF) return KIND_IF;
		if (len == 16'd3 && tail == TXT_LET) return KIND_LET;
		if (len == 16'd3 && tail == TXT_MUT) return KIND_MUT;
		if (len == 16'd6 && tail == TXT_RETURN) return KIND_RETURN;
		if (len == 16'd4 && tail == TXT_TRUE) return KIND_BOOL;
		if (len == 16'd5 && tail == TXT_FALSE) return KIND_BOOL;
		return K_IDENT;
	endfunction

	task automatic reset_scan();
		lex_mode = LEX_IDLE;
		held_op = 8'd0;
		tok_start = 16'd0;
		byte_pos = 16'd0;
		line_cnt = 16'd1;
		word_tail = 48'd0;
		discarding = 1'b0;
	endtask

	task automatic push_token(input logic [5:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic [1:0] err, input logic fin);
		token_t t;
		t.kind = kind;
		t.start = start;
		t.len = len;
		t.line = line_cnt;
		t.err = err;
		t.fin = fin;
		tokens_due.push_back(t);
	endtask

	task automatic abort_scan(input logic [15:0] start, input logic [15:0] len,
			input logic [1:0] code);
		push_token(K_EOF, start, len, code, 1'b1);
		discarding = 1'b1;
	endtask

	task automatic close_word();
		push_token(word_kind(word_tail, run_length(tok_start)), tok_start,
			run_length(tok_start), ERR_NONE, 1'b0);
	endtask

	task automatic scan_char(input logic [7:0] c);
		logic [15:0] pos;
		logic [5:0]  k;
		logic        open;
		pos = byte_pos;
		open = 1'b1;
		case (lex_mode)
			LEX_WORD: begin
				if (is_letter(c) || is_numeral(c) || c == "_") begin
					word_tail = {word_tail[39:0], c};
					open = 1'b0;
				end else begin
					close_word();
					lex_mode = LEX_IDLE;
				end
			end
			LEX_NUMBER: begin
				if (is_numeral(c)) begin
					open = 1'b0;
				end else begin
					push_token(K_NUMBER, tok_start, run_length(tok_start), ERR_NONE, 1'b0);
					lex_mode = LEX_IDLE;
				end
			end
			LEX_STRING: begin
				open = 1'b0;
				if (c == CH_QUOTE) begin
					push_token(K_STRING, tok_start, run_length(tok_start), ERR_NONE, 1'b0);
					lex_mode = LEX_IDLE;
				end else if (c == CH_LF) begin
					line_cnt = sat_bump(line_cnt);
				end
			end
			LEX_COMMENT: begin
				if (c != CH_LF)
					open = 1'b0;
				else
					lex_mode = LEX_IDLE;
			end
			LEX_OPERATOR: begin
				if (held_op == "&" || held_op == "|") begin
					open = 1'b0;
					if (c == held_op) begin
						push_token((held_op == "&") ? K_AND : K_OR, tok_start, 16'd2,
							ERR_NONE, 1'b0);
						lex_mode = LEX_IDLE;
					end else begin
						abort_scan(tok_start, 16'd1, ERR_CHAR);
					end
				end else if (held_op == "/" && c == "/") begin
					lex_mode = LEX_COMMENT;
					open = 1'b0;
				end else begin
					k = assign_op_kind(held_op);
					lex_mode = LEX_IDLE;
					if (c == "=") begin
						push_token(k + 6'd1, tok_start, 16'd2, ERR_NONE, 1'b0);
						open = 1'b0;
					end else begin
						push_token(k, tok_start, 16'd1, ERR_NONE, 1'b0);
					end
				end
			end
			default: lex_mode = LEX_IDLE;
		endcase
		if (open) begin
			k = punct_kind(c);
			if (c == " " || c == CH_CR) begin
			end else if (c == CH_LF) begin
				line_cnt = sat_bump(line_cnt);
			end else if (k != K_EOF) begin
				push_token(k, pos, 16'd1, ERR_NONE, 1'b0);
			end else if (assign_op_kind(c) != K_EOF || c == "&" || c == "|") begin
				lex_mode = LEX_OPERATOR;
				held_op = c;
				tok_start = pos;
			end else if (c == CH_QUOTE) begin
				lex_mode = LEX_STRING;
				tok_start = sat_bump(pos);
			end else if (is_numeral(c)) begin
				lex_mode = LEX_NUMBER;
				tok_start = pos;
			end else if (is_letter(c) || c == "_") begin
				lex_mode = LEX_WORD;
				tok_start = pos;
				word_tail = {40'd0, c};
			end else begin
				abort_scan(pos, 16'd1, ERR_CHAR);
			end
		end
	endtask

	task automatic predict_beat(input logic [7:0] c, input logic eos);
		if (eos) begin
			if (!discarding) begin
				case (lex_mode)
					LEX_WORD: close_word();
					LEX_NUMBER: push_token(K_NUMBER, tok_start, run_length(tok_start),
						ERR_NONE, 1'b0);
					LEX_STRING: abort_scan(tok_start, run_length(tok_start), ERR_STRING);
					LEX_OPERATOR: begin
						if (held_op == "&" || held_op == "|")
							abort_scan(tok_start, 16'd1, ERR_CHAR);
						else
							push_token(assign_op_kind(held_op), tok_start, 16'd1, ERR_NONE, 1'b0);
					end
					default: ;
				endcase
				if (!discarding)
					push_token(K_EOF, byte_pos, 16'd0, ERR_NONE, 1'b1);
			end
			reset_scan();
		end else begin
			if (!discarding)
				scan_char(c);
			byte_pos = sat_bump(byte_pos);
		end
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: token mismatch, %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic check_token();
		token_t want;
		if (tokens_due.size() == 0) begin
			report($sformatf("unexpected beat kind %0d start %0d", m_tuser[5:0], m_tdata[15:0]));
			return;
		end
		want = tokens_due.pop_front();
		compare_field("kind", 16'(m_tuser[5:0]), 16'(want.kind));
		compare_field("start", m_tdata[15:0], want.start);
		compare_field("length", m_tdata[31:16], want.len);
		compare_field("line", m_tdata[47:32], want.line);
		compare_field("error", 16'(m_tuser[7:6]), 16'(want.err));
		compare_field("last", 16'(m_tlast), 16'(want.fin));
	endtask

	// receiver: check, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_token();
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_source_tokenizer: FAIL");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		predict_beat(c, eos);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tokens_due.size() != 0);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			src_q.push_back(s[i]);
	endtask

	task automatic send_source();
		foreach (src_q[i])
			send_beat(src_q[i], 1'b0);
		send_beat(8'($urandom_range(255)), 1'b1);
		src_q.delete();
	endtask

	function automatic logic [7:0] word_char(input logic lead);
		int r;
		r = lead ? $urandom_range(52) : $urandom_range(62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic string keyword_text(input int i);
		case (i)
			0: return "else";
			1: return "fn";
			2: return "if";
			3: return "let";
			4: return "mut";
			5: return "return";
			6: return "true";
			default: return "false";
		endcase
	endfunction

	function automatic logic [7:0] string_char();
		int r;
		r = $urandom_range(19);
		if (r == 0) return CH_LF;
		if (r == 1) return 8'($urandom_range(128, 255));
		r = $urandom_range(32, 126);
		return (r == CH_QUOTE) ? "q" : 8'(r);
	endfunction

	task automatic add_lexeme();
		int r;
		int n;
		string chars;
		r = $urandom_range(99);
		if (r < 12) begin
			add_text(keyword_text($urandom_range(7)));
		end else if (r < 24) begin
			if ($urandom_range(3) == 0) begin
				add_text(keyword_text($urandom_range(7)));
				src_q.push_back(word_char(1'b0));
			end else begin
				src_q.push_back(word_char(1'b1));
				n = $urandom_range(8);
				repeat (n) src_q.push_back(word_char(1'b0));
			end
		end else if (r < 34) begin
			n = $urandom_range(1, 5);
			repeat (n) src_q.push_back(8'("0" + $urandom_range(9)));
		end else if (r < 44) begin
			src_q.push_back(CH_QUOTE);
			n = $urandom_range(6);
			repeat (n) src_q.push_back(string_char());
			src_q.push_back(CH_QUOTE);
		end else if (r < 58) begin
			chars = "(){}:;,";
			n = $urandom_range(6);
			src_q.push_back(chars[n]);
		end else if (r < 78) begin
			chars = "=!+-*/%<>";
			n = $urandom_range(8);
			src_q.push_back(chars[n]);
			if ($urandom_range(1))
				add_text("=");
		end else if (r < 84) begin
			add_text($urandom_range(1) ? "&&" : "||");
		end else if (r < 90) begin
			add_text("//");
			n = $urandom_range(6);
			repeat (n) src_q.push_back(8'($urandom_range(32, 255)));
			if ($urandom_range(4) != 0)
				src_q.push_back(CH_LF);
		end else begin
			case ($urandom_range(2))
				0: add_text(" ");
				1: src_q.push_back(CH_CR);
				default: src_q.push_back(CH_LF);
			endcase
		end
	endtask

	task automatic add_noise();
		case ($urandom_range(3))
			0: src_q.push_back(8'($urandom_range(255)));
			1: src_q.push_back(CH_TAB);
			2: begin
				add_text("&");
				src_q.push_back(word_char(1'b0));
			end
			default: add_text("| ");
		endcase
	endtask

	task automatic build_source();
		int n;
		n = $urandom_range(1, 12);
		repeat (n) begin
			if ($urandom_range(99) < 3)
				add_noise();
			else
				add_lexeme();
			case ($urandom_range(19))
				0, 1, 2, 3, 4: ;
				5, 6, 7: src_q.push_back(CH_LF);
				default: add_text(" ");
			endcase
		end
		if ($urandom_range(19) == 0) begin
			src_q.push_back(CH_QUOTE);
			src_q.push_back(string_char());
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_text("x");
		src_q.push_back(CH_TAB);
		add_text("y");
		send_source();
		add_text("&x");
		send_source();
		add_text("|");
		send_source();
		add_text("\"ab");
		send_source();
		src_q.push_back(8'h00);
		send_source();
		src_q.push_back(8'hFF);
		send_source();
		send_source();
		add_text("a>=1//c");
		src_q.push_back(CH_LF);
		send_source();
		drain();
	endtask

	task automatic test_random(input int unsigned count, input int idle_pct,
			input int stall_pct);
		int unsigned target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(19) == 0)
				drain();
			build_source();
			send_source();
		end
		drain();
	endtask

	// long receiver hold while single tokens keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		repeat (24) add_text("(");
		send_source();
		drain();
	endtask

	task automatic test_line_runs();
		send_idle_pct = 0;
		recv_stall_pct = 10;
		repeat (40) send_beat(CH_LF, 1'b0);
		src_q.push_back(CH_QUOTE);
		repeat (20) src_q.push_back(CH_LF);
		src_q.push_back(CH_QUOTE);
		add_text("ab 7");
		repeat (10) src_q.push_back(CH_LF);
		add_text("x");
		send_source();
		drain();
	endtask

	initial begin
		reset_scan();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(330, 0, 0);
		test_random(330, 53, 0);
		test_random(330, 0, 53);
		test_random(330, 16, 16);
		test_backpressure();
		test_line_runs();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tokens_due.size() == 0)
			$display("tb_source_tokenizer: PASS");
		else
			$display("tb_source_tokenizer: FAIL");
		$finish;
	end

endmodule
